// ===== design/fcw_pkg.sv =====
// Shared types and constants for the front-coded word table lookup.
`timescale 1ns / 1ps
`default_nettype none
package fcw_pkg;

	localparam int MAX_WORDS_DEF = 1024;
	localparam int MAX_LEN_DEF   = 32;

	localparam logic [7:0] CHAR_MASK = 8'h7F;

	localparam logic REQ_FILE  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_FULL  = 2'd1;
	localparam logic [1:0] ERR_LONG  = 2'd2;
	localparam logic [1:0] ERR_TRUNC = 2'd3;

	typedef enum logic [2:0] {
		PH_OFF_HI,
		PH_OFF_LO,
		PH_SKIP,
		PH_PREFIX,
		PH_CHARS,
		PH_SYN_HI,
		PH_SYN_LO,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY,
		ST_CHECK,
		ST_MID,
		ST_BASE,
		ST_RD,
		ST_CMP
	} state_t;

endpackage
`default_nettype wire

// ===== design/fcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== design/front_coded_word_table_lookup.sv =====
// Top level: word-file loader, query gatherer and binary search sequencer.
//
// Usage: drive req_type/data/last with start; a word is taken at a clock edge
// where start is high and busy is low. File words (req_type 0) build a table
// kept in file order; query characters (req_type 1) gather a word that is searched once
// its last character arrives. Each result shows on the result ports for one
// cycle with strobe high; the receiver cannot stall it.
// A file byte leaves busy low, except the one that completes a stored
// entry, which holds busy while all MAX_LEN character slots of the word are
// copied into the character memory. A non-final query character leaves busy
// low. A final query character holds busy for the search: a check state,
// then, for each probe of the binary search (at most log2(count)+1 probes),
// a midpoint state and a base state plus a read and a compare state per
// compared character, all on the one character memory read port.
// Results appear on the cycle after the decision is made.
// Reset clears the control state, working word and counters; the table
// memories hold nothing meaningful until a load writes them.
`timescale 1ns / 1ps
`default_nettype none
module front_coded_word_table_lookup #(
	parameter int MAX_WORDS = fcw_pkg::MAX_WORDS_DEF,
	parameter int MAX_LEN   = fcw_pkg::MAX_LEN_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            req_type,
	input  wire logic [7:0]                      data,
	input  wire logic                            last,
	output logic                                 strobe,
	output logic                                 result_kind,
	output logic                                 found,
	output logic [15:0]                          synonym,
	output logic [$clog2(MAX_WORDS+1)-1:0]       word_total,
	output logic [1:0]                           load_error
);
	import fcw_pkg::*;

	localparam int CW  = $clog2(MAX_WORDS + 1);
	localparam int AW  = $clog2(MAX_WORDS);
	localparam int LW  = $clog2(MAX_LEN + 1);
	localparam int IW  = $clog2(MAX_LEN);
	localparam int CD  = MAX_WORDS * MAX_LEN;
	localparam int CAW = $clog2(CD);

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	logic [6:0]    ww_q [MAX_LEN];
	logic [6:0]    ww_d [MAX_LEN];
	logic [LW-1:0] wlen_q, wlen_d;
	logic [15:0]   pos_q, pos_d;
	logic [15:0]   off_q, off_d;
	logic [7:0]    synh_q, synh_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [1:0]    err_q, err_d;
	logic          drop_q, drop_d;

	logic [7:0]    q_q [MAX_LEN];
	logic [7:0]    q_d [MAX_LEN];
	logic [LW-1:0] qlen_q, qlen_d;
	logic          qovf_q, qovf_d;

	logic [CW-1:0]  lo_q, lo_d, hx_q, hx_d;
	logic [AW-1:0]  mid_q, mid_d;
	logic [CAW-1:0] base_q, base_d, wbase_q, wbase_d;
	logic [IW-1:0]  i_q, i_d;

	logic          strobe_q, strobe_d;
	logic          kind_q, kind_d, found_q, found_d;
	logic [15:0]   syn_q, syn_d;
	logic [CW-1:0] tot_q, tot_d;
	logic [1:0]    lerr_q, lerr_d;

	// memory ports
	logic           len_we;
	logic [LW-1:0]  len_rd;
	logic [15:0]    synw, syn_rd;
	logic [6:0]     chr_rd;
	logic [CAW-1:0] chr_waddr, chr_raddr;

	// scratch for the combinational block
	logic          fresh, do_prefix, usable;
	logic [CW-1:0] cnt_e;
	logic [15:0]   pos_e;
	logic [CW:0]   msum;
	logic [7:0]    ca, cb;
	logic [6:0]    dec;

	assign busy      = (state_q != ST_IDLE);
	assign chr_waddr = wbase_q + CAW'(i_q);
	assign chr_raddr = base_q + CAW'(i_q);

	fcw_ram #(.WIDTH(7), .DEPTH(CD)) u_chars (
		.clk(clk), .we(state_q == ST_COPY), .waddr(chr_waddr), .wdata(ww_q[i_q]),
		.raddr(chr_raddr), .rdata(chr_rd)
	);
	fcw_ram #(.WIDTH(LW), .DEPTH(MAX_WORDS)) u_lens (
		.clk(clk), .we(len_we), .waddr(cnt_e[AW-1:0]), .wdata(wlen_d),
		.raddr(mid_q), .rdata(len_rd)
	);
	fcw_ram #(.WIDTH(16), .DEPTH(MAX_WORDS)) u_syns (
		.clk(clk), .we(len_we), .waddr(cnt_e[AW-1:0]), .wdata(synw),
		.raddr(mid_q), .rdata(syn_rd)
	);

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		ww_d     = ww_q;
		wlen_d   = wlen_q;
		pos_d    = pos_q;
		off_d    = off_q;
		synh_d   = synh_q;
		cnt_d    = cnt_q;
		err_d    = err_q;
		drop_d   = drop_q;
		q_d      = q_q;
		qlen_d   = qlen_q;
		qovf_d   = qovf_q;
		lo_d     = lo_q;
		hx_d     = hx_q;
		mid_d    = mid_q;
		base_d   = base_q;
		wbase_d  = wbase_q;
		i_d      = i_q;
		strobe_d = 1'b0;
		kind_d   = kind_q;
		found_d  = found_q;
		syn_d    = syn_q;
		tot_d    = tot_q;
		lerr_d   = lerr_q;
		len_we   = 1'b0;
		synw     = {synh_q, data};
		fresh    = 1'b0;
		do_prefix = 1'b0;
		usable   = 1'b0;
		cnt_e    = cnt_q;
		pos_e    = pos_q;
		msum     = '0;
		ca       = '0;
		cb       = '0;
		dec      = 7'((data ^ CHAR_MASK) & CHAR_MASK);

		case (state_q)
			ST_IDLE: begin
				if (start && req_type == REQ_FILE) begin
					fresh = (phase_q == PH_DONE);
					if (fresh) begin
						// new load: drop the previous table
						phase_d = PH_OFF_HI;
						for (int k = 0; k < MAX_LEN; k++) ww_d[k] = '0;
						wlen_d = '0;
						pos_d  = '0;
						off_d  = '0;
						synh_d = '0;
						cnt_d  = '0;
						err_d  = ERR_OK;
						drop_d = 1'b0;
					end
					cnt_e = cnt_d;
					pos_e = pos_d;
					if (pos_d != 16'hFFFF) pos_d = pos_d + 16'd1;
					case (phase_d)
						PH_OFF_HI: begin
							off_d   = {data, 8'h00};
							phase_d = PH_OFF_LO;
						end
						PH_OFF_LO: begin
							off_d   = {off_d[15:8], data};
							phase_d = PH_SKIP;
						end
						PH_SKIP: begin
							do_prefix = (pos_e >= off_d);
						end
						PH_PREFIX: begin
							do_prefix = 1'b1;
						end
						PH_CHARS: begin
							if (!drop_d) begin
								if (wlen_d < LW'(MAX_LEN)) begin
									ww_d[wlen_d[IW-1:0]] = dec;
									wlen_d = wlen_d + LW'(1);
								end else begin
									drop_d = 1'b1;
									if (err_d == ERR_OK) err_d = ERR_LONG;
								end
							end
							if (data[7]) begin
								if (!drop_d && wlen_d < LW'(MAX_LEN))
									ww_d[wlen_d[IW-1:0]] = '0;
								phase_d = PH_SYN_HI;
							end
						end
						PH_SYN_HI: begin
							synh_d  = data;
							phase_d = PH_SYN_LO;
						end
						PH_SYN_LO: begin
							if (!drop_d) begin
								if (cnt_d < CW'(MAX_WORDS)) begin
									// commit: length and synonym now, characters by sweep
									len_we  = 1'b1;
									wbase_d = CAW'(CAW'(cnt_d) * CAW'(MAX_LEN));
									i_d     = '0;
									state_d = ST_COPY;
									cnt_d   = cnt_d + CW'(1);
								end else if (err_d == ERR_OK) begin
									err_d = ERR_FULL;
								end
							end
							drop_d  = 1'b0;
							phase_d = PH_PREFIX;
						end
						default: ;
					endcase
					if (do_prefix) begin
						drop_d = 1'b0;
						if (data > 8'(MAX_LEN)) begin
							drop_d = 1'b1;
							if (err_d == ERR_OK) err_d = ERR_LONG;
						end else begin
							wlen_d = LW'(data);
						end
						phase_d = PH_CHARS;
					end
					if (last) begin
						if (phase_d != PH_PREFIX && phase_d != PH_SKIP && err_d == ERR_OK)
							err_d = ERR_TRUNC;
						strobe_d = 1'b1;
						kind_d   = KIND_LOAD;
						found_d  = 1'b0;
						syn_d    = '0;
						tot_d    = cnt_d;
						lerr_d   = err_d;
						phase_d  = PH_DONE;
						drop_d   = 1'b0;
					end
				end else if (start) begin
					if (qlen_q < LW'(MAX_LEN)) begin
						q_d[qlen_q[IW-1:0]] = data;
						qlen_d = qlen_q + LW'(1);
					end else begin
						qovf_d = 1'b1;
					end
					if (last) state_d = ST_CHECK;
				end
			end
			ST_COPY: begin
				if (i_q == IW'(MAX_LEN - 1)) state_d = ST_IDLE;
				else i_d = i_q + IW'(1);
			end
			ST_CHECK: begin
				usable = !qovf_q;
				for (int k = 0; k < MAX_LEN; k++)
					if (LW'(k) < qlen_q && q_q[k] == 8'h00) usable = 1'b1;
				lo_d = '0;
				hx_d = usable ? cnt_q : '0;
				state_d = ST_MID;
			end
			ST_MID: begin
				if (lo_q < hx_q) begin
					msum    = {1'b0, lo_q} + {1'b0, hx_q} - (CW+1)'(1);
					mid_d   = AW'(msum >> 1);
					state_d = ST_BASE;
				end else begin
					strobe_d = 1'b1;
					kind_d   = KIND_LOOKUP;
					found_d  = 1'b0;
					syn_d    = '0;
					tot_d    = '0;
					lerr_d   = ERR_OK;
					qlen_d   = '0;
					qovf_d   = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			ST_BASE: begin
				base_d  = CAW'(CAW'(mid_q) * CAW'(MAX_LEN));
				i_d     = '0;
				state_d = ST_RD;
			end
			ST_RD: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				ca = (LW'(i_q) < qlen_q) ? q_q[i_q] : 8'h00;
				cb = (LW'(i_q) < len_rd) ? {1'b0, chr_rd} : 8'h00;
				if (ca != cb) begin
					if (ca < cb) hx_d = CW'(mid_q);
					else lo_d = CW'(mid_q) + CW'(1);
					state_d = ST_MID;
				end else if (ca == 8'h00 || i_q == IW'(MAX_LEN - 1)) begin
					strobe_d = 1'b1;
					kind_d   = KIND_LOOKUP;
					found_d  = 1'b1;
					syn_d    = syn_rd;
					tot_d    = '0;
					lerr_d   = ERR_OK;
					qlen_d   = '0;
					qovf_d   = 1'b0;
					state_d  = ST_IDLE;
				end else begin
					i_d     = i_q + IW'(1);
					state_d = ST_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_OFF_HI;
			for (int k = 0; k < MAX_LEN; k++) ww_q[k] <= '0;
			wlen_q   <= '0;
			pos_q    <= '0;
			off_q    <= '0;
			synh_q   <= '0;
			cnt_q    <= '0;
			err_q    <= ERR_OK;
			drop_q   <= 1'b0;
			qlen_q   <= '0;
			qovf_q   <= 1'b0;
			lo_q     <= '0;
			hx_q     <= '0;
			i_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			ww_q     <= ww_d;
			wlen_q   <= wlen_d;
			pos_q    <= pos_d;
			off_q    <= off_d;
			synh_q   <= synh_d;
			cnt_q    <= cnt_d;
			err_q    <= err_d;
			drop_q   <= drop_d;
			qlen_q   <= qlen_d;
			qovf_q   <= qovf_d;
			lo_q     <= lo_d;
			hx_q     <= hx_d;
			i_q      <= i_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		q_q     <= q_d;
		mid_q   <= mid_d;
		base_q  <= base_d;
		wbase_q <= wbase_d;
		kind_q  <= kind_d;
		found_q <= found_d;
		syn_q   <= syn_d;
		tot_q   <= tot_d;
		lerr_q  <= lerr_d;
	end

	assign strobe      = strobe_q;
	assign result_kind = kind_q;
	assign found       = found_q;
	assign synonym     = syn_q;
	assign word_total  = tot_q;
	assign load_error  = lerr_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_WORDS)) else $error("stored count beyond table");
	a_found_kind: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && found |-> result_kind == KIND_LOOKUP) else $error("found on load report");
	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MID |-> hx_q <= cnt_q) else $error("search window past count");
	a_copy_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COPY && i_q == IW'(MAX_LEN - 1) |=> state_q == ST_IDLE)
		else $error("copy sweep overran");
endmodule
`default_nettype wire
